[hw/rtl/bash_pkg.sv]
// shared types, constants and protocol byte codes for the bill acceptor serial handler
// no dependencies; imported by every module of the block
package bash_pkg;

    // field widths
    localparam int unsigned OP_W     = 3;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned VALUE_W  = 20;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned CNT_W    = 8;
    localparam int unsigned WORD_W   = 60;
    localparam int unsigned BCOUNT_W = 4;
    localparam int unsigned OUT_DATA_W = 40;

    // up to three results per input item
    localparam int unsigned RES_MAX = 3;
    localparam int unsigned RES_IDX_W = 2;

    // configuration port
    localparam int unsigned APB_ADDR_W = 6;
    localparam int unsigned APB_DATA_W = 64;
    localparam int unsigned REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_DENOM_A   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DENOM_B   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_DENOM_C   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DENOM_D   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_BILL_CNT  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_INH_MODE  = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_TABLE_ERR = 3'd6;

    // register reset values
    localparam logic [WORD_W-1:0]   DENOM_A_RST   = 60'd5497559187456500;
    localparam logic [WORD_W-1:0]   DENOM_B_RST   = 60'd109951215206410000;
    localparam logic [WORD_W-1:0]   DENOM_C_RST   = 60'd0;
    localparam logic [VALUE_W-1:0]  DENOM_D_RST   = 20'd0;
    localparam logic [BCOUNT_W-1:0] BILL_CNT_RST  = 4'd6;
    localparam logic                INH_MODE_RST  = 1'b1;
    localparam logic                TABLE_ERR_RST = 1'b0;

    // timer defaults
    localparam int unsigned POLL_TICKS_DEF         = 20;
    localparam int unsigned LINK_TIMEOUT_TICKS_DEF = 200;
    localparam int unsigned RESET_POLL_TICKS_DEF   = 150;

    // operations
    localparam logic [OP_W-1:0] OP_RX      = 3'd0;
    localparam logic [OP_W-1:0] OP_TICK    = 3'd1;
    localparam logic [OP_W-1:0] OP_RESET   = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE  = 3'd3;
    localparam logic [OP_W-1:0] OP_INHIBIT = 3'd4;

    // result kinds
    localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CMD    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CREDIT = 2'd2;

    // bytes from the acceptor
    localparam logic [BYTE_W-1:0] RX_POWER_UP   = 8'h80;
    localparam logic [BYTE_W-1:0] RX_POWER_DONE = 8'h8F;
    localparam logic [BYTE_W-1:0] RX_VALIDATED  = 8'h81;
    localparam logic [BYTE_W-1:0] RX_STACKED    = 8'h10;
    localparam logic [BYTE_W-1:0] RX_RETURNED   = 8'h11;
    localparam logic [BYTE_W-1:0] RX_FAIL_MOTOR = 8'h20;
    localparam logic [BYTE_W-1:0] RX_FAIL_CHKSM = 8'h21;
    localparam logic [BYTE_W-1:0] RX_FAIL_JAM   = 8'h22;
    localparam logic [BYTE_W-1:0] RX_FAIL_REMOV = 8'h24;
    localparam logic [BYTE_W-1:0] RX_FAIL_SENS  = 8'h25;
    localparam logic [BYTE_W-1:0] RX_FISHING    = 8'h27;
    localparam logic [BYTE_W-1:0] RX_FAIL_ROM   = 8'h28;
    localparam logic [BYTE_W-1:0] RX_ENABLED    = 8'h3E;
    localparam logic [BYTE_W-1:0] RX_INHIBITED  = 8'h5E;
    localparam logic [BYTE_W-1:0] RX_DENOM_LO   = 8'h40;
    localparam logic [BYTE_W-1:0] RX_DENOM_HI   = 8'h49;

    // commands to the acceptor
    localparam logic [BYTE_W-1:0] CMD_ACCEPT  = 8'h02;
    localparam logic [BYTE_W-1:0] CMD_REJECT  = 8'h0F;
    localparam logic [BYTE_W-1:0] CMD_POLL    = 8'h0C;
    localparam logic [BYTE_W-1:0] CMD_ENABLE  = 8'h3E;
    localparam logic [BYTE_W-1:0] CMD_INHIBIT = 8'h5E;
    localparam logic [BYTE_W-1:0] CMD_RESET   = 8'h30;

    typedef struct packed {
        logic [WORD_W-1:0]   denom_a;
        logic [WORD_W-1:0]   denom_b;
        logic [WORD_W-1:0]   denom_c;
        logic [VALUE_W-1:0]  denom_d;
        logic [BCOUNT_W-1:0] bill_count;
        logic                inhibit_mode;
        logic                table_error;
    } bash_cfg_t;

    typedef struct packed {
        logic               power_step;
        logic [VALUE_W-1:0] held_value;
        logic               validated;
        logic               enabled;
        logic               failure;
        logic               fishing;
        logic               link_fail;
        logic               inhibit_pending;
        logic               enable_pending;
        logic [CNT_W-1:0]   poll_count;
        logic [CNT_W-1:0]   link_count;
    } bash_state_t;

    typedef struct packed {
        logic is_enabled;
        logic has_failure;
        logic is_fishing;
        logic link_failed;
        logic bill_validated;
    } bash_flags_t;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [BYTE_W-1:0]  tx_byte;
        logic [VALUE_W-1:0] credit_value;
    } bash_result_t;

endpackage

[hw/rtl/bash_cfg.sv]
// configuration register file behind an apb-style port
// depends on bash_pkg
module bash_cfg
    import bash_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output bash_cfg_t             cfg
);

    bash_cfg_t              cfg_reg;
    logic [REG_IDX_W-1:0]   reg_idx;
    logic                   wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:3];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.denom_a      <= DENOM_A_RST;
            cfg_reg.denom_b      <= DENOM_B_RST;
            cfg_reg.denom_c      <= DENOM_C_RST;
            cfg_reg.denom_d      <= DENOM_D_RST;
            cfg_reg.bill_count   <= BILL_CNT_RST;
            cfg_reg.inhibit_mode <= INH_MODE_RST;
            cfg_reg.table_error  <= TABLE_ERR_RST;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_DENOM_A:   cfg_reg.denom_a      <= pwdata[WORD_W-1:0];
                REG_DENOM_B:   cfg_reg.denom_b      <= pwdata[WORD_W-1:0];
                REG_DENOM_C:   cfg_reg.denom_c      <= pwdata[WORD_W-1:0];
                REG_DENOM_D:   cfg_reg.denom_d      <= pwdata[VALUE_W-1:0];
                REG_BILL_CNT:  cfg_reg.bill_count   <= pwdata[BCOUNT_W-1:0];
                REG_INH_MODE:  cfg_reg.inhibit_mode <= pwdata[0];
                REG_TABLE_ERR: cfg_reg.table_error  <= pwdata[0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (reg_idx)
            REG_DENOM_A:   prdata = APB_DATA_W'(cfg_reg.denom_a);
            REG_DENOM_B:   prdata = APB_DATA_W'(cfg_reg.denom_b);
            REG_DENOM_C:   prdata = APB_DATA_W'(cfg_reg.denom_c);
            REG_DENOM_D:   prdata = APB_DATA_W'(cfg_reg.denom_d);
            REG_BILL_CNT:  prdata = APB_DATA_W'(cfg_reg.bill_count);
            REG_INH_MODE:  prdata = APB_DATA_W'(cfg_reg.inhibit_mode);
            REG_TABLE_ERR: prdata = APB_DATA_W'(cfg_reg.table_error);
            default:       prdata = '0;
        endcase
    end

endmodule

[hw/rtl/bash_step.sv]
// combinational protocol step: next state and up to three results for one item
// depends on bash_pkg
module bash_step
    import bash_pkg::*;
#(
    parameter int unsigned POLL_TICKS         = POLL_TICKS_DEF,
    parameter int unsigned LINK_TIMEOUT_TICKS = LINK_TIMEOUT_TICKS_DEF,
    parameter int unsigned RESET_POLL_TICKS   = RESET_POLL_TICKS_DEF
)
(
    input  logic [OP_W-1:0]                 operation,
    input  logic [BYTE_W-1:0]               rx_data,
    input  bash_cfg_t                       cfg,
    input  bash_state_t                     state,
    output bash_state_t                     state_next,
    output bash_result_t [RES_MAX-1:0]      res,
    output logic [RES_IDX_W-1:0]            res_num,
    output bash_flags_t                     flags
);

    logic [3:0]         denom_idx;
    logic [VALUE_W-1:0] denom_val;
    logic [VALUE_W-1:0] entry_val;
    logic [CNT_W-1:0]   poll_dec;
    logic [CNT_W-1:0]   link_dec;

    assign denom_idx = rx_data[3:0];

    // denomination table lookup
    always_comb
    begin
        case (denom_idx)
            4'd0:    denom_val = cfg.denom_a[19:0];
            4'd1:    denom_val = cfg.denom_a[39:20];
            4'd2:    denom_val = cfg.denom_a[59:40];
            4'd3:    denom_val = cfg.denom_b[19:0];
            4'd4:    denom_val = cfg.denom_b[39:20];
            4'd5:    denom_val = cfg.denom_b[59:40];
            4'd6:    denom_val = cfg.denom_c[19:0];
            4'd7:    denom_val = cfg.denom_c[39:20];
            4'd8:    denom_val = cfg.denom_c[59:40];
            default: denom_val = cfg.denom_d;
        endcase
    end

    // index past the count or a bad table rejects
    assign entry_val = (denom_idx < cfg.bill_count && !cfg.table_error) ? denom_val : '0;

    assign poll_dec = (state.poll_count != '0) ? state.poll_count - 1'b1 : '0;
    assign link_dec = (state.link_count != '0) ? state.link_count - 1'b1 : '0;

    always_comb
    begin
        state_next = state;
        res        = '0;
        res_num    = '0;
        unique case (operation)
            OP_RX:
            begin
                state_next.power_step = (rx_data == RX_POWER_UP);
                unique case (rx_data) inside
                    RX_POWER_DONE:
                    begin
                        if (state.power_step)
                        begin
                            state_next.fishing = 1'b0;
                            res[0] = '{kind: KIND_CMD, tx_byte: CMD_ACCEPT, credit_value: '0};
                            res[1] = '{kind: KIND_CMD,
                                       tx_byte: (cfg.table_error || cfg.inhibit_mode) ?
                                                CMD_INHIBIT : CMD_ENABLE,
                                       credit_value: '0};
                            res[2] = '{kind: KIND_CMD, tx_byte: CMD_POLL, credit_value: '0};
                            res_num = 2'd3;
                        end
                    end
                    RX_VALIDATED:
                        state_next.validated = 1'b1;
                    RX_STACKED:
                    begin
                        if (state.held_value != '0 && state.validated)
                        begin
                            res[0] = '{kind: KIND_CREDIT, tx_byte: '0,
                                       credit_value: state.held_value};
                            res_num = 2'd1;
                            state_next.validated  = 1'b0;
                            state_next.held_value = '0;
                        end
                    end
                    RX_RETURNED:
                    begin
                        state_next.validated  = 1'b0;
                        state_next.held_value = '0;
                    end
                    RX_FAIL_MOTOR, RX_FAIL_CHKSM, RX_FAIL_JAM, RX_FAIL_REMOV,
                    RX_FAIL_SENS, RX_FAIL_ROM:
                        state_next.failure = 1'b1;
                    RX_FISHING:
                        state_next.fishing = 1'b1;
                    RX_ENABLED:
                    begin
                        state_next.enabled = 1'b1;
                        if (state.inhibit_pending)
                        begin
                            res[0] = '{kind: KIND_CMD, tx_byte: CMD_INHIBIT, credit_value: '0};
                            res_num = 2'd1;
                            state_next.inhibit_pending = 1'b0;
                        end
                    end
                    RX_INHIBITED:
                    begin
                        state_next.enabled = 1'b0;
                        if (state.enable_pending)
                        begin
                            res[0] = '{kind: KIND_CMD, tx_byte: CMD_ENABLE, credit_value: '0};
                            res_num = 2'd1;
                            state_next.enable_pending = 1'b0;
                        end
                    end
                    [RX_DENOM_LO:RX_DENOM_HI]:
                    begin
                        state_next.held_value = entry_val;
                        res[0] = '{kind: KIND_CMD,
                                   tx_byte: (entry_val != '0) ? CMD_ACCEPT : CMD_REJECT,
                                   credit_value: '0};
                        res_num = 2'd1;
                    end
                    default: ;
                endcase
                // any byte proves the link alive
                state_next.poll_count = CNT_W'(POLL_TICKS);
                state_next.link_count = CNT_W'(LINK_TIMEOUT_TICKS);
                state_next.link_fail  = 1'b0;
            end
            OP_TICK:
            begin
                state_next.poll_count = poll_dec;
                state_next.link_count = link_dec;
                if (poll_dec == '0)
                begin
                    state_next.poll_count = CNT_W'(POLL_TICKS);
                    res[0] = '{kind: KIND_CMD, tx_byte: CMD_POLL, credit_value: '0};
                    res_num = 2'd1;
                end
                if (link_dec == '0)
                    state_next.link_fail = 1'b1;
            end
            OP_RESET:
            begin
                res[0] = '{kind: KIND_CMD, tx_byte: CMD_RESET, credit_value: '0};
                res_num = 2'd1;
                state_next.poll_count = CNT_W'(RESET_POLL_TICKS);
                state_next.link_count = CNT_W'(LINK_TIMEOUT_TICKS);
                state_next.fishing    = 1'b0;
                state_next.enabled    = 1'b0;
                state_next.failure    = 1'b0;
                state_next.power_step = 1'b0;
                state_next.validated  = 1'b0;
            end
            OP_ENABLE:
                state_next.enable_pending = 1'b1;
            OP_INHIBIT:
                state_next.inhibit_pending = 1'b1;
            default: ;
        endcase
        // nothing sent: one status-only result
        if (res_num == '0)
        begin
            res[0]  = '{kind: KIND_STATUS, tx_byte: '0, credit_value: '0};
            res_num = 2'd1;
        end
    end

    assign flags.is_enabled     = state_next.enabled;
    assign flags.has_failure    = state_next.failure;
    assign flags.is_fishing     = state_next.fishing;
    assign flags.link_failed    = state_next.link_fail;
    assign flags.bill_validated = state_next.validated;

endmodule

[hw/rtl/bash_outbuf.sv]
// result register holding up to three results of one item, drained one per transfer
// depends on bash_pkg
module bash_outbuf
    import bash_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         load,
    input  bash_result_t [RES_MAX-1:0]   res,
    input  logic [RES_IDX_W-1:0]         res_num,
    input  bash_flags_t                  flags,
    output logic                         free,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [OUT_DATA_W-1:0]        m_axis_tdata,
    output logic [KIND_W-1:0]            m_axis_tuser,
    output logic                         m_axis_tlast
);

    bash_result_t [RES_MAX-1:0] res_reg;
    bash_flags_t                flags_reg;
    logic [RES_IDX_W-1:0]       num_reg;
    logic [RES_IDX_W-1:0]       idx_reg;
    logic                       valid_reg;
    logic                       is_last;
    logic                       xfer;
    bash_result_t               cur;

    assign is_last = (idx_reg == RES_IDX_W'(num_reg - 1'b1));
    assign xfer    = valid_reg && m_axis_tready;
    assign free    = !valid_reg || (xfer && is_last);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
            num_reg   <= '0;
        end
        else if (load)
        begin
            valid_reg <= 1'b1;
            idx_reg   <= '0;
            num_reg   <= res_num;
        end
        else if (xfer)
        begin
            if (is_last)
                valid_reg <= 1'b0;
            else
                idx_reg <= idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg   <= res;
            flags_reg <= flags;
        end
    end

    assign cur           = res_reg[idx_reg];
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = is_last;
    assign m_axis_tdata  = {7'd0,
                            flags_reg.bill_validated,
                            flags_reg.link_failed,
                            flags_reg.is_fishing,
                            flags_reg.has_failure,
                            flags_reg.is_enabled,
                            cur.credit_value,
                            cur.tx_byte};

endmodule

[hw/rtl/bill_acceptor_serial_handler_core.sv]
// bill acceptor serial handler, top level: input register, protocol step, result register
// an item waits in the input register until the result register is free, then loads into it
// throughput: one item per cycle while each item yields one result and tready stays high;
//   an n-result item holds the result register for n output transfers, which sets its rate
// reset: rst_n asynchronous active low; clears protocol state, timers to reload values,
//   configuration registers to their defaults; no clearing pass
module bill_acceptor_serial_handler_core
    import bash_pkg::*;
#(
    parameter int unsigned POLL_TICKS         = POLL_TICKS_DEF,
    parameter int unsigned LINK_TIMEOUT_TICKS = LINK_TIMEOUT_TICKS_DEF,
    parameter int unsigned RESET_POLL_TICKS   = RESET_POLL_TICKS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // input items
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [BYTE_W-1:0]     s_axis_tdata,   // [7:0] rx_data
    input  logic [OP_W-1:0]       s_axis_tuser,   // [2:0] operation

    // result items
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [7:0] tx_byte, [27:8] credit_value, [28] is_enabled, [29] has_failure,
    // [30] is_fishing, [31] link_failed, [32] bill_validated, [39:33] zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic [KIND_W-1:0]     m_axis_tuser,   // [1:0] kind
    output logic                  m_axis_tlast,   // last result of this item

    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    bash_cfg_t                  cfg;

    // input register, acts as the skid stage in front of the step logic
    logic                       in_valid_reg;
    logic [OP_W-1:0]            op_reg;
    logic [BYTE_W-1:0]          data_reg;

    // protocol state
    bash_state_t                state_reg;
    bash_state_t                state_next;

    bash_result_t [RES_MAX-1:0] res;
    logic [RES_IDX_W-1:0]       res_num;
    bash_flags_t                flags;
    logic                       buf_free;
    logic                       buf_load;
    logic                       in_xfer;

    // the step result moves into the result register once it is empty
    // or its last result leaves in this cycle
    assign buf_load      = in_valid_reg && buf_free;
    assign s_axis_tready = !in_valid_reg || buf_load;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    bash_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_xfer)
            in_valid_reg <= 1'b1;
        else if (buf_load)
            in_valid_reg <= 1'b0;
    end

    // payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            op_reg   <= s_axis_tuser;
            data_reg <= s_axis_tdata;
        end
    end

    bash_step #(
        .POLL_TICKS         (POLL_TICKS),
        .LINK_TIMEOUT_TICKS (LINK_TIMEOUT_TICKS),
        .RESET_POLL_TICKS   (RESET_POLL_TICKS)
    ) u_step (
        .operation  (op_reg),
        .rx_data    (data_reg),
        .cfg        (cfg),
        .state      (state_reg),
        .state_next (state_next),
        .res        (res),
        .res_num    (res_num),
        .flags      (flags)
    );

    // state commits together with the results of the item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.power_step      <= 1'b0;
            state_reg.held_value      <= '0;
            state_reg.validated       <= 1'b0;
            state_reg.enabled         <= 1'b0;
            state_reg.failure         <= 1'b0;
            state_reg.fishing         <= 1'b0;
            state_reg.link_fail       <= 1'b0;
            state_reg.inhibit_pending <= 1'b0;
            state_reg.enable_pending  <= 1'b0;
            state_reg.poll_count      <= CNT_W'(RESET_POLL_TICKS);
            state_reg.link_count      <= CNT_W'(LINK_TIMEOUT_TICKS);
        end
        else if (buf_load)
        begin
            state_reg <= state_next;
        end
    end

    bash_outbuf u_outbuf (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (buf_load),
        .res           (res),
        .res_num       (res_num),
        .flags         (flags),
        .free          (buf_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
